@@ hdl/sha_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and constant tables of the SHA-256 stream hasher.
// No dependencies; every other file imports this package.
package sha_pkg;

    localparam int BlockWords = 16;
    localparam int ChainWords = 8;
    localparam int Rounds     = 64;
    localparam int TotalBits  = 61;

    // First word index that no longer leaves room for the 64-bit length.
    localparam logic [3:0] LenWordHi = 4'd14;
    localparam logic [3:0] LenWordLo = 4'd15;
    localparam logic [7:0] PadByte   = 8'h80;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HLOAD,
        ST_ROUND,
        ST_HSTORE,
        ST_PAD,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_WAIT
    } state_t;

    // Where the sequencer goes once a compression has been folded into the chain.
    typedef enum logic [1:0] {
        RET_IDLE,
        RET_PAD,
        RET_OUT
    } ret_t;

    typedef struct packed {
        logic       load_shift;
        logic       sched_en;
        logic       sched_mem;
        logic [5:0] sched_idx;
        logic       round_en;
    } round_ctrl_t;

    function automatic logic [31:0] iv_const(input logic [2:0] idx);
        logic [31:0] v;
        unique case (idx)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] k_const(input logic [5:0] t);
        logic [31:0] v;
        unique case (t)
            6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
            6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
            6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
            6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
            6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
            6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
            6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
            6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
            6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
            6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
            6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
            6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
            6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
            6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
            6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
            6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
            6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
            6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
            6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
            6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
            6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
            6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
            6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
            6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
            6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
            6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
            6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
            6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
            6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
            6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
            6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
            6'd62: v = 32'hbef9a3f7;  default: v = 32'hc67178f2;
        endcase
        return v;
    endfunction

endpackage

@@ hdl/sha_block_ram.sv @@
`timescale 1ns / 1ps
// Message block memory: sixteen 32-bit big-endian words, one write and one
// registered read per cycle. Depends on sha_pkg.
module sha_block_ram (
    input  logic        aclk,
    input  logic        wr_en,
    input  logic [3:0]  wr_addr,
    input  logic [31:0] wr_data,
    input  logic [3:0]  rd_addr,
    output logic [31:0] rd_data
);
    import sha_pkg::*;

    logic [31:0] mem_reg [BlockWords];
    logic [31:0] q_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        q_reg <= mem_reg[rd_addr];
    end

    assign rd_data = q_reg;

endmodule

@@ hdl/sha_chain_ram.sv @@
`timescale 1ns / 1ps
// Chaining value memory: eight 32-bit words with a valid bit each; an entry
// that is not valid reads as the SHA-256 initial value. Depends on sha_pkg.
module sha_chain_ram (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        clear,
    input  logic        wr_en,
    input  logic [2:0]  wr_addr,
    input  logic [31:0] wr_data,
    input  logic [2:0]  rd_addr,
    output logic [31:0] rd_data
);
    import sha_pkg::*;

    logic [31:0]           mem_reg [ChainWords];
    logic [ChainWords-1:0] valid_reg;
    logic [31:0]           q_reg;
    logic                  iv_sel_reg;
    logic [2:0]            ridx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (clear) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        q_reg      <= mem_reg[rd_addr];
        iv_sel_reg <= !valid_reg[rd_addr];
        ridx_reg   <= rd_addr;
    end

    assign rd_data = iv_sel_reg ? iv_const(ridx_reg) : q_reg;

endmodule

@@ hdl/sha_round_unit.sv @@
`timescale 1ns / 1ps
// Compression datapath: working variables a..h, the sixteen-word schedule
// window and the precomputed K+W register. Depends on sha_pkg.
module sha_round_unit (
    input  logic                aclk,
    input  sha_pkg::round_ctrl_t ctrl,
    input  logic [31:0]         blk_rdata,
    input  logic [31:0]         chain_rdata,
    output logic [31:0]         wv_head
);
    import sha_pkg::*;

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    logic [31:0] wv_reg  [ChainWords];
    logic [31:0] win_reg [BlockWords];
    logic [31:0] wk_reg;
    logic [31:0] w_new;
    logic [31:0] t1;
    logic [31:0] t2;

    // The window holds W[t-16] at index 0 up to W[t-1] at index 15.
    always_comb begin
        if (ctrl.sched_mem) begin
            w_new = blk_rdata;
        end else begin
            w_new = ssig1(win_reg[14]) + win_reg[9] + ssig0(win_reg[1]) + win_reg[0];
        end
        t1 = wv_reg[7] + bsig1(wv_reg[4])
           + ((wv_reg[4] & wv_reg[5]) ^ (~wv_reg[4] & wv_reg[6])) + wk_reg;
        t2 = bsig0(wv_reg[0])
           + ((wv_reg[0] & wv_reg[1]) ^ (wv_reg[0] & wv_reg[2]) ^ (wv_reg[1] & wv_reg[2]));
    end

    always_ff @(posedge aclk) begin
        if (ctrl.sched_en) begin
            for (int i = 0; i < BlockWords - 1; i++) begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[BlockWords-1] <= w_new;
            wk_reg <= w_new + k_const(ctrl.sched_idx);
        end
        if (ctrl.round_en) begin
            wv_reg[7] <= wv_reg[6];
            wv_reg[6] <= wv_reg[5];
            wv_reg[5] <= wv_reg[4];
            wv_reg[4] <= wv_reg[3] + t1;
            wv_reg[3] <= wv_reg[2];
            wv_reg[2] <= wv_reg[1];
            wv_reg[1] <= wv_reg[0];
            wv_reg[0] <= t1 + t2;
        end else if (ctrl.load_shift) begin
            // Shift toward index 0 so that a..h line up with chain words 0..7.
            for (int i = 0; i < ChainWords - 1; i++) begin
                wv_reg[i] <= wv_reg[i+1];
            end
            wv_reg[ChainWords-1] <= chain_rdata;
        end
    end

    assign wv_head = wv_reg[0];

endmodule

@@ hdl/sha256_stream_hasher.sv @@
`timescale 1ns / 1ps
// SHA-256 stream hasher top level: sequencer, byte packing and padding.
// Depends on sha_pkg, sha_block_ram, sha_chain_ram and sha_round_unit.
//
// Message bytes enter one per request on the slave side (tuser marks whether
// tdata carries a byte, tlast closes the message after this request). A byte
// that does not complete a 64-byte block and does not close the message is
// taken without a stall. The request that completes a block, and every
// close, stalls s_tready while the block is compressed: the chaining value
// is loaded from its memory into the working registers, the rounds run (the
// schedule runs one step ahead of the round logic) and the result is added
// back into the chaining memory, limited by the single read port of the
// chaining memory and the one round per cycle. A close first writes the
// padding words, one word per cycle from the current word to word 15, and
// needs a second padding pass and a second compression when 56 or more
// bytes remain in the last block. The eight digest words then leave on the
// master side, word 0 first, with the word index in tuser and tlast on
// word 7; each word passes through a read, a load and a wait state, the
// last held while the receiver stalls. After the last word is taken the
// chaining value returns to the SHA-256 initial value and the byte count to
// zero, ready for the next message. The block buffer needs no clearing:
// every entry is written before a compression reads it.
module sha256_stream_hasher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] byte_present
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast    // last_word
);
    import sha_pkg::*;

    state_t state_reg, state_next;
    ret_t   ret_reg, ret_next;

    logic [6:0]           cnt_reg, cnt_next;
    logic [TotalBits-1:0] total_reg, total_next;
    logic [23:0]          acc_reg, acc_next;
    logic [3:0]           pwi_reg, pwi_next;
    logic                 pad_first_reg, pad_first_next;
    logic                 len_pass_reg, len_pass_next;
    logic [31:0]          out_word_reg, out_word_next;

    logic                 s_accept;
    logic [TotalBits-1:0] total_inc;
    logic [5:0]           new_pos;
    logic [31:0]          pad_word;
    logic [63:0]          bit_len;

    logic        blk_we;
    logic [3:0]  blk_waddr;
    logic [31:0] blk_wdata;
    logic [3:0]  blk_raddr;
    logic [31:0] blk_rdata;

    logic        chain_clear;
    logic        chain_we;
    logic [2:0]  chain_waddr;
    logic [31:0] chain_wdata;
    logic [2:0]  chain_raddr;
    logic [31:0] chain_rdata;

    round_ctrl_t rctrl;
    logic [31:0] wv_head;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign total_inc = total_reg + {{(TotalBits-1){1'b0}}, 1'b1};
    assign new_pos   = s_tuser ? total_inc[5:0] : total_reg[5:0];
    assign bit_len   = {total_reg, 3'b000};

    // First padding word: the bytes already packed, then 0x80, then zeros.
    always_comb begin
        case (total_reg[1:0])
            2'd0:    pad_word = {PadByte, 24'd0};
            2'd1:    pad_word = {acc_reg[7:0], PadByte, 16'd0};
            2'd2:    pad_word = {acc_reg[15:0], PadByte, 8'd0};
            default: pad_word = {acc_reg[23:0], PadByte};
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_tuser && (total_reg[5:0] == 6'd63)) begin
                        state_next = ST_HLOAD;
                    end else if (s_tlast) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (pwi_reg == LenWordLo) begin
                    state_next = ST_HLOAD;
                end
            end
            ST_HLOAD: begin
                if (cnt_reg == 7'd8) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (cnt_reg == 7'(Rounds)) begin
                    state_next = ST_HSTORE;
                end
            end
            ST_HSTORE: begin
                if (cnt_reg == 7'd8) begin
                    unique case (ret_reg)
                        RET_PAD: state_next = ST_PAD;
                        RET_OUT: state_next = ST_OUT_RD;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_OUT_RD:   state_next = ST_OUT_LD;
            ST_OUT_LD:   state_next = ST_OUT_WAIT;
            ST_OUT_WAIT: begin
                if (m_tready) begin
                    state_next = (cnt_reg[2:0] == 3'd7) ? ST_IDLE : ST_OUT_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath control and register updates.
    always_comb begin
        cnt_next       = cnt_reg;
        ret_next       = ret_reg;
        total_next     = total_reg;
        acc_next       = acc_reg;
        pwi_next       = pwi_reg;
        pad_first_next = pad_first_reg;
        len_pass_next  = len_pass_reg;
        out_word_next  = out_word_reg;

        blk_we      = 1'b0;
        blk_waddr   = total_reg[5:2];
        blk_wdata   = {acc_reg, s_tdata};
        blk_raddr   = '0;
        chain_clear = 1'b0;
        chain_we    = 1'b0;
        chain_waddr = cnt_reg[2:0] - 3'd1;
        chain_wdata = chain_rdata + wv_head;
        chain_raddr = '0;
        rctrl       = '0;

        unique case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (s_accept) begin
                    if (s_tuser) begin
                        total_next = total_inc;
                        acc_next   = {acc_reg[15:0], s_tdata};
                        blk_we     = (total_reg[1:0] == 2'd3);
                    end
                    // Every accepted request sets up the padding now, in case it closes; it
                    // survives a compression that the same request may start first.
                    pwi_next       = new_pos[5:2];
                    pad_first_next = 1'b1;
                    len_pass_next  = (new_pos[5:2] < LenWordHi);
                    ret_next       = s_tlast ? RET_PAD : RET_IDLE;
                end
            end
            ST_PAD: begin
                blk_we    = 1'b1;
                blk_waddr = pwi_reg;
                blk_wdata = pad_first_reg ? pad_word : 32'd0;
                if (len_pass_reg && (pwi_reg == LenWordHi)) begin
                    blk_wdata = bit_len[63:32];
                end else if (len_pass_reg && (pwi_reg == LenWordLo)) begin
                    blk_wdata = bit_len[31:0];
                end
                pad_first_next = 1'b0;
                pwi_next       = pwi_reg + 4'd1;
                if (pwi_reg == LenWordLo) begin
                    cnt_next      = '0;
                    ret_next      = len_pass_reg ? RET_OUT : RET_PAD;
                    len_pass_next = 1'b1;
                end
            end
            ST_HLOAD: begin
                chain_raddr      = cnt_reg[2:0];
                rctrl.load_shift = (cnt_reg != 7'd0);
                if (cnt_reg == 7'd8) begin
                    cnt_next = '0;
                end else begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            ST_ROUND: begin
                // Word t is read in the cycle before the schedule step that uses it.
                blk_raddr       = cnt_reg[3:0] + 4'd1;
                rctrl.sched_en  = !cnt_reg[6];
                rctrl.sched_mem = (cnt_reg < 7'(BlockWords));
                rctrl.sched_idx = cnt_reg[5:0];
                rctrl.round_en  = (cnt_reg != 7'd0);
                if (cnt_reg == 7'(Rounds)) begin
                    cnt_next = '0;
                end else begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            ST_HSTORE: begin
                // Reads run one entry ahead of the write-back, so no entry is
                // read and written in the same cycle.
                chain_raddr      = cnt_reg[2:0];
                chain_we         = (cnt_reg != 7'd0);
                rctrl.load_shift = (cnt_reg != 7'd0);
                if (cnt_reg == 7'd8) begin
                    cnt_next = '0;
                end else begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            ST_OUT_RD: begin
                chain_raddr = cnt_reg[2:0];
            end
            ST_OUT_LD: begin
                out_word_next = chain_rdata;
            end
            ST_OUT_WAIT: begin
                if (m_tready) begin
                    if (cnt_reg[2:0] == 3'd7) begin
                        chain_clear = 1'b1;
                        total_next  = '0;
                        cnt_next    = '0;
                    end else begin
                        cnt_next = cnt_reg + 7'd1;
                    end
                end
            end
            default: begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ret_reg       <= RET_IDLE;
            cnt_reg       <= '0;
            total_reg     <= '0;
            pwi_reg       <= '0;
            pad_first_reg <= 1'b0;
            len_pass_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            cnt_reg       <= cnt_next;
            total_reg     <= total_next;
            pwi_reg       <= pwi_next;
            pad_first_reg <= pad_first_next;
            len_pass_reg  <= len_pass_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg      <= acc_next;
        out_word_reg <= out_word_next;
    end

    assign m_tvalid = (state_reg == ST_OUT_WAIT);
    assign m_tdata  = out_word_reg;
    assign m_tuser  = cnt_reg[2:0];
    assign m_tlast  = (cnt_reg[2:0] == 3'd7);

    sha_block_ram u_block_ram (
        .aclk    (aclk),
        .wr_en   (blk_we),
        .wr_addr (blk_waddr),
        .wr_data (blk_wdata),
        .rd_addr (blk_raddr),
        .rd_data (blk_rdata)
    );

    sha_chain_ram u_chain_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (chain_clear),
        .wr_en   (chain_we),
        .wr_addr (chain_waddr),
        .wr_data (chain_wdata),
        .rd_addr (chain_raddr),
        .rd_data (chain_rdata)
    );

    sha_round_unit u_round_unit (
        .aclk        (aclk),
        .ctrl        (rctrl),
        .blk_rdata   (blk_rdata),
        .chain_rdata (chain_rdata),
        .wv_head     (wv_head)
    );

    // Input and output never run at the same time.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input accepted while a digest word is pending");

    // Taking the final digest word restarts the message state.
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && (total_reg == '0)))
        else $error("message state not restarted after the last digest word");

    // The chaining write-back never collides with a read of the same entry.
    a_chain_rw: assert property (@(posedge aclk) disable iff (!aresetn)
        chain_we |-> (chain_waddr != chain_raddr))
        else $error("chaining memory read and write at the same entry");

    // A byte that fills the block starts a compression at once.
    a_full_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser && (total_reg[5:0] == 6'd63)) |=> (state_reg == ST_HLOAD))
        else $error("full block not compressed");

endmodule
